// ----- rtl/core/protobuf_data_message_decoder_core_defines.svh -----
// Assertion helpers used by the decoder RTL.
`ifndef PROTOBUF_DATA_MESSAGE_DECODER_CORE_DEFINES_SVH
`define PROTOBUF_DATA_MESSAGE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define PDMD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define PDMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pdmd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pdmd_pkg;

  // Payload capacity per payload field
  localparam int PAYLOAD_MAX   = 256;
  localparam int PAYLOAD_LEN_W = $clog2(PAYLOAD_MAX + 1);
  localparam logic [PAYLOAD_LEN_W-1:0] PAYLOAD_CAP = PAYLOAD_LEN_W'(PAYLOAD_MAX);

  // Result queue between parser and output
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // Result kinds
  localparam logic [1:0] KIND_SCALAR  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END_OK  = 2'd2;
  localparam logic [1:0] KIND_END_ERR = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  field_id;
    logic [31:0] value;
    logic [7:0]  payload_index;
    logic        last;
  } result_t;

  // One result request from the parser to the queue
  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

endpackage

`default_nettype wire

// ----- rtl/core/pdmd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "protobuf_data_message_decoder_core_defines.svh"

module pdmd_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           in_mode,
  input  wire logic [7:0]     in_byte,
  output pdmd_pkg::push_t     res
);

  typedef enum logic [2:0] {
    PH_TAG,
    PH_VALUE,
    PH_FIXED,
    PH_LENGTH,
    PH_BODY
  } phase_t;

  // Field numbers
  localparam logic [7:0] FN_PORTNUM    = 8'd1;
  localparam logic [7:0] FN_PAYLOAD    = 8'd2;
  localparam logic [7:0] FN_WANT_RESP  = 8'd3;
  localparam logic [7:0] FN_DEST       = 8'd4;
  localparam logic [7:0] FN_SOURCE     = 8'd5;
  localparam logic [7:0] FN_REQUEST_ID = 8'd6;
  localparam logic [7:0] FN_REPLY_ID   = 8'd7;
  localparam logic [7:0] FN_SKIPPED    = 8'd8;
  localparam logic [7:0] FN_BITFIELD   = 8'd9;

  // Wire types
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_I64    = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_I32    = 3'd5;

  localparam logic [3:0] VARINT_LAST = 4'd9;
  localparam logic [3:0] FIXED_LAST  = 4'd3;

  phase_t                              phase, phase_next;
  logic [63:0]                         acc, acc_next;
  logic [3:0]                          shift_count, shift_count_next;
  logic [7:0]                          fld_num, fld_num_next;
  logic [2:0]                          wire_kind, wire_kind_next;
  logic [63:0]                         bytes_remaining, bytes_remaining_next;
  logic [pdmd_pkg::PAYLOAD_LEN_W-1:0]  payload_position, payload_position_next;
  logic [pdmd_pkg::PAYLOAD_LEN_W-1:0]  payload_length, payload_length_next;
  logic                                error_seen, error_seen_next;

  logic [5:0]  vi_shamt;
  logic [63:0] vi_acc;
  logic        vi_done;
  logic        vi_fail;
  logic [31:0] fx_acc;
  logic [7:0]  fn;
  logic [2:0]  wk;
  logic [63:0] br_dec;

  // Bit offset of the current 7-bit varint group
  always_comb begin
    case (shift_count)
      4'd0:    vi_shamt = 6'd0;
      4'd1:    vi_shamt = 6'd7;
      4'd2:    vi_shamt = 6'd14;
      4'd3:    vi_shamt = 6'd21;
      4'd4:    vi_shamt = 6'd28;
      4'd5:    vi_shamt = 6'd35;
      4'd6:    vi_shamt = 6'd42;
      4'd7:    vi_shamt = 6'd49;
      4'd8:    vi_shamt = 6'd56;
      4'd9:    vi_shamt = 6'd63;
      default: vi_shamt = 6'd0;
    endcase
  end

  // Varint and fixed-width byte merge
  assign vi_acc  = acc | ({57'b0, in_byte[6:0]} << vi_shamt);
  assign vi_done = !in_byte[7];
  assign vi_fail = in_byte[7] && (shift_count >= VARINT_LAST);
  assign fx_acc  = acc[31:0] | ({24'b0, in_byte} << {shift_count[1:0], 3'b000});
  assign fn      = vi_acc[10:3];
  assign wk      = vi_acc[2:0];
  assign br_dec  = (bytes_remaining != 64'd0) ? bytes_remaining - 64'd1 : 64'd0;

  // Parser next state and result
  always_comb begin
    phase_next            = phase;
    acc_next              = acc;
    shift_count_next      = shift_count;
    fld_num_next          = fld_num;
    wire_kind_next        = wire_kind;
    bytes_remaining_next  = bytes_remaining;
    payload_position_next = payload_position;
    payload_length_next   = payload_length;
    error_seen_next       = error_seen;
    res                   = '0;

    if (in_valid) begin
      if (in_mode) begin
        // End of message: report and return to reset state
        res.valid = 1'b1;
        res.res.last = 1'b1;
        if (error_seen || (phase != PH_TAG) || (shift_count != 4'd0)) begin
          res.res.kind = pdmd_pkg::KIND_END_ERR;
        end else begin
          res.res.kind  = pdmd_pkg::KIND_END_OK;
          res.res.value = 32'(payload_length);
        end
        phase_next            = PH_TAG;
        acc_next              = '0;
        shift_count_next      = '0;
        fld_num_next          = '0;
        wire_kind_next        = '0;
        bytes_remaining_next  = '0;
        payload_position_next = '0;
        payload_length_next   = '0;
        error_seen_next       = 1'b0;
      end else if (!error_seen) begin
        case (phase)
          PH_TAG: begin
            acc_next = vi_acc;
            if (vi_fail) begin
              error_seen_next = 1'b1;
            end else if (!vi_done) begin
              shift_count_next = shift_count + 4'd1;
            end else begin
              fld_num_next      = fn;
              wire_kind_next    = wk;
              acc_next          = '0;
              shift_count_next  = '0;
              case (fn)
                FN_PORTNUM, FN_WANT_RESP, FN_BITFIELD: begin
                  if (wk != WT_VARINT) error_seen_next = 1'b1;
                  else phase_next = PH_VALUE;
                end
                FN_PAYLOAD: begin
                  if (wk != WT_LEN) error_seen_next = 1'b1;
                  else phase_next = PH_LENGTH;
                end
                FN_DEST, FN_SOURCE, FN_REQUEST_ID, FN_REPLY_ID, FN_SKIPPED: begin
                  if (wk != WT_I32) error_seen_next = 1'b1;
                  else phase_next = PH_FIXED;
                end
                default: begin
                  // Unknown field: skip by wire type
                  if (wk == WT_VARINT) begin
                    phase_next = PH_VALUE;
                  end else if (wk == WT_I32) begin
                    phase_next = PH_FIXED;
                  end else if (wk == WT_LEN) begin
                    phase_next = PH_LENGTH;
                  end else if (wk == WT_I64) begin
                    phase_next           = PH_BODY;
                    bytes_remaining_next = 64'd8;
                  end else begin
                    error_seen_next = 1'b1;
                  end
                end
              endcase
            end
          end

          PH_VALUE: begin
            acc_next = vi_acc;
            if (vi_fail) begin
              error_seen_next = 1'b1;
            end else if (!vi_done) begin
              shift_count_next = shift_count + 4'd1;
            end else begin
              phase_next       = PH_TAG;
              acc_next         = '0;
              shift_count_next = '0;
              res.res.kind     = pdmd_pkg::KIND_SCALAR;
              res.res.field_id = 4'(fld_num);
              if ((fld_num == FN_PORTNUM) || (fld_num == FN_BITFIELD)) begin
                res.valid     = 1'b1;
                res.res.value = vi_acc[31:0];
              end else if (fld_num == FN_WANT_RESP) begin
                res.valid     = 1'b1;
                res.res.value = {31'b0, (vi_acc != 64'd0)};
              end
            end
          end

          PH_FIXED: begin
            if (shift_count < FIXED_LAST) begin
              acc_next         = {32'b0, fx_acc};
              shift_count_next = shift_count + 4'd1;
            end else begin
              phase_next       = PH_TAG;
              acc_next         = '0;
              shift_count_next = '0;
              res.res.kind     = pdmd_pkg::KIND_SCALAR;
              res.res.field_id = 4'(fld_num);
              res.res.value    = fx_acc;
              res.valid        = (fld_num >= FN_DEST) && (fld_num <= FN_REPLY_ID);
            end
          end

          PH_LENGTH: begin
            acc_next = vi_acc;
            if (vi_fail) begin
              error_seen_next = 1'b1;
            end else if (!vi_done) begin
              shift_count_next = shift_count + 4'd1;
            end else begin
              acc_next         = '0;
              shift_count_next = '0;
              if (fld_num == FN_PAYLOAD) begin
                payload_length_next = (vi_acc > 64'(pdmd_pkg::PAYLOAD_MAX)) ?
                                      pdmd_pkg::PAYLOAD_CAP :
                                      vi_acc[pdmd_pkg::PAYLOAD_LEN_W-1:0];
              end
              if (vi_acc == 64'd0) begin
                phase_next = PH_TAG;
              end else begin
                phase_next            = PH_BODY;
                bytes_remaining_next  = vi_acc;
                payload_position_next = '0;
              end
            end
          end

          PH_BODY: begin
            // Payload bytes go out up to capacity, the rest are dropped
            if ((fld_num == FN_PAYLOAD) && (wire_kind == WT_LEN) &&
                (payload_position < pdmd_pkg::PAYLOAD_CAP)) begin
              res.valid             = 1'b1;
              res.res.kind          = pdmd_pkg::KIND_PAYLOAD;
              res.res.value         = {24'b0, in_byte};
              res.res.payload_index = 8'(payload_position);
              payload_position_next = payload_position + 1'b1;
            end
            bytes_remaining_next = br_dec;
            if (br_dec == 64'd0) begin
              phase_next       = PH_TAG;
              acc_next         = '0;
              shift_count_next = '0;
            end
          end

          default: begin
            error_seen_next = 1'b1;
          end
        endcase
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_TAG;
      acc              <= '0;
      shift_count      <= '0;
      fld_num          <= '0;
      wire_kind        <= '0;
      bytes_remaining  <= '0;
      payload_position <= '0;
      payload_length   <= '0;
      error_seen       <= 1'b0;
    end else begin
      phase            <= phase_next;
      acc              <= acc_next;
      shift_count      <= shift_count_next;
      fld_num          <= fld_num_next;
      wire_kind        <= wire_kind_next;
      bytes_remaining  <= bytes_remaining_next;
      payload_position <= payload_position_next;
      payload_length   <= payload_length_next;
      error_seen       <= error_seen_next;
    end
  end

  // Checks
  `PDMD_ASSERT_NEXT(a_end_clears, clk, rst, in_valid && in_mode, (phase == PH_TAG) && !error_seen && (shift_count == 4'd0) && (payload_length == '0), "end item did not clear parser state")
  `PDMD_ASSERT_IMPL(a_err_silent, clk, rst, in_valid && !in_mode && error_seen, !res.valid, "result after error")
  `PDMD_ASSERT_IMPL(a_last_on_end, clk, rst, res.valid, (res.res.last == in_mode) && in_valid, "last flag not tied to end item")
  `PDMD_ASSERT_IMPL(a_payload_src, clk, rst, res.valid && (res.res.kind == pdmd_pkg::KIND_PAYLOAD), (phase == PH_BODY) && (fld_num == FN_PAYLOAD), "payload byte outside payload body")

endmodule

`default_nettype wire

// ----- rtl/core/pdmd_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pdmd_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  pdmd_pkg::push_t         push,
  output logic                    ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pdmd_pkg::result_t       out_res
);

  pdmd_pkg::result_t                 mem [pdmd_pkg::FIFO_DEPTH];
  logic [pdmd_pkg::FIFO_PTR_W-1:0]   wr_ptr;
  logic [pdmd_pkg::FIFO_PTR_W-1:0]   rd_ptr;
  logic [pdmd_pkg::FIFO_PTR_W:0]     count;
  logic                              pop;

  assign ready     = (count != (pdmd_pkg::FIFO_PTR_W + 1)'(pdmd_pkg::FIFO_DEPTH));
  assign out_valid = (count != '0);
  assign out_res   = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  // Result storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.res;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/protobuf_data_message_decoder_core.sv -----
// Streaming decoder for one protobuf Data message.
// Input channel (s_*): one item per request; s_tuser = 1 marks the end of the
// message, otherwise s_tdata carries the next encoded byte.
// Output channel (m_*): scalar fields, payload bytes and one end result
// (m_tlast high) per message; m_tuser gives the result kind.
// Throughput: one input byte per cycle while s_tready is high, set by the
// combinational varint merge and the 64-bit body countdown in the parser.
// A result is written into the result queue when the request that causes it
// is accepted and shows on m_tvalid once the results ahead of it are taken.
// A 4-entry result queue sits between parser and output; when m_tready is low
// the queue fills and s_tready drops once it holds 4 results.
// Reset (rst, synchronous): parser returns to expecting a tag, the queue is
// emptied, so s_tready is high after reset.
// After the end item all parser state returns to its reset value.
`timescale 1ns / 1ps
`default_nettype none

module protobuf_data_message_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [3:0] field_id, [35:4] value, [43:36] payload_index
  output logic [1:0]       m_tuser,   // [1:0] kind
  output logic             m_tlast    // last
);

  pdmd_pkg::push_t   push;
  pdmd_pkg::result_t out_res;
  logic              in_accept;

  assign in_accept = s_tvalid && s_tready;

  // Front: byte parser
  pdmd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_accept),
    .in_mode  (s_tuser),
    .in_byte  (s_tdata),
    .res      (push)
  );

  // Back: result queue toward the output channel
  pdmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .ready     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // Output packing
  assign m_tdata = {4'b0, out_res.payload_index, out_res.value, out_res.field_id};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule

`default_nettype wire
